[rtl/fcfs_round_robin_job_scheduler_assert.svh]
// Assertion macros for the job scheduler RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef FCFS_ROUND_ROBIN_JOB_SCHEDULER_ASSERT_SVH
`define FCFS_ROUND_ROBIN_JOB_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define FRRJS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRRJS_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define FRRJS_ASSERT(lbl, prop, msg)
`define FRRJS_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif
`endif

[rtl/frrjs_pkg.sv]
// Shared constants, types and codes of the job scheduler.
// No dependencies; used by the interfaces and every module.
package frrjs_pkg;

    localparam int MAX_JOBS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int SLOT_BITS     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int COUNT_BITS    = $clog2(MAX_JOBS + 1);
    localparam int PID_BITS      = 16;
    localparam int BURST_BITS    = 16;
    localparam int SLICE_BITS    = 16;
    localparam int OUT_TIME_BITS = 32;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [0:0] {
        FUNC_ADMIT = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POLICY_MODE  = 1'b0,
        CFG_SLICE_LENGTH = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        POLICY_FCFS = 1'b0,
        POLICY_RR   = 1'b1
    } policy_t;

    typedef logic [SLOT_BITS-1:0]     slot_t;
    typedef logic [COUNT_BITS-1:0]    count_t;
    typedef logic [TIME_BITS-1:0]     time_t;
    typedef logic [PID_BITS-1:0]      pid_t;
    typedef logic [BURST_BITS-1:0]    burst_t;
    typedef logic [SLICE_BITS-1:0]    slice_t;
    typedef logic [OUT_TIME_BITS-1:0] out_time_t;

    typedef struct packed {
        pid_t   pid;
        time_t  arrival;
        burst_t remaining;
        logic   started;
    } job_entry_t;

    typedef struct packed {
        logic       wr_en;
        slot_t      wr_addr;
        job_entry_t wr_data;
        logic       rd_en;
        slot_t      rd_addr;
    } tbl_req_t;

    typedef struct packed {
        logic  push;
        slot_t push_slot;
        logic  pop;
    } q_req_t;

    typedef struct packed {
        count_t count;
        slot_t  head_slot;
    } q_stat_t;

endpackage

[rtl/frrjs_if.sv]
// Valid/ready channel interfaces: job input, result output, register writes.
// Depends on frrjs_pkg.
interface frrjs_job_if;
    import frrjs_pkg::*;
    logic   valid;
    logic   ready;
    logic   func;
    pid_t   job_pid;
    burst_t burst_ticks;

    modport source (output valid, func, job_pid, burst_ticks, input ready);
    modport sink (input valid, func, job_pid, burst_ticks, output ready);
endinterface

interface frrjs_result_if;
    import frrjs_pkg::*;
    logic      valid;
    logic      ready;
    logic      accepted;
    out_time_t tick_time;
    logic      ran;
    pid_t      run_pid;
    logic      first_start;
    out_time_t response_time;
    logic      finished;
    out_time_t turnaround;
    logic      context_switch;

    modport source (output valid, accepted, tick_time, ran, run_pid, first_start,
                    response_time, finished, turnaround, context_switch, input ready);
    modport sink (input valid, accepted, tick_time, ran, run_pid, first_start,
                  response_time, finished, turnaround, context_switch, output ready);
endinterface

interface frrjs_cfg_if;
    import frrjs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/frrjs_table.sv]
// Job table memory: pid, arrival, remaining ticks and started flag per slot.
// One write port, one synchronous read port; depends on frrjs_pkg.
module frrjs_table
(
    input  logic                    clk,
    input  frrjs_pkg::tbl_req_t     req,
    output frrjs_pkg::job_entry_t   rd_data
);
    import frrjs_pkg::*;

    job_entry_t mem [MAX_JOBS];
    job_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/frrjs_queue.sv]
// Ready queue: ring of slot numbers in a memory with head, tail and count.
// Pop registers the head entry onto head_slot for the next cycle; depends on frrjs_pkg and the assert header.
`include "fcfs_round_robin_job_scheduler_assert.svh"
module frrjs_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  frrjs_pkg::q_req_t  req,
    output frrjs_pkg::q_stat_t stat
);
    import frrjs_pkg::*;

    slot_t  mem [MAX_JOBS];
    slot_t  rd_data_reg;
    slot_t  head_reg;
    slot_t  head_next;
    slot_t  tail_reg;
    slot_t  tail_next;
    count_t count_reg;
    count_t count_next;

    function automatic slot_t wrap_inc(input slot_t p);
        if (p == slot_t'(MAX_JOBS - 1))
        begin
            return '0;
        end
        return p + slot_t'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= req.push_slot;
        end
        if (req.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_comb
    begin
        head_next  = req.pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = req.push ? wrap_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (req.push && !req.pop)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (req.pop && !req.push)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.count     = count_reg;
    assign stat.head_slot = rd_data_reg;

    `FRRJS_ASSERT(a_q_no_overflow, !(req.push && count_reg == count_t'(MAX_JOBS)), "queue push while full")
    `FRRJS_ASSERT(a_q_no_underflow, !(req.pop && count_reg == '0), "queue pop while empty")
    `FRRJS_ASSERT_NEXT(a_q_push_count, req.push && !req.pop, count_reg == $past(count_reg) + 1'b1, "queue count missed a push")

endmodule

[rtl/fcfs_round_robin_job_scheduler.sv]
// Tick-driven FCFS / round robin job scheduler. An admit beat, and a tick beat with no job to
// run, are handled in S_IDLE alone; a tick that runs the current job passes S_TRD (job table
// read, then write-back), and a tick that dispatches from the ready queue passes S_QRD and
// S_TRD (queue head read, job table read, write-back). The queue and job table memories have
// registered reads. A new beat is taken once the previous one is finished and the output
// register is empty or hands its beat over in that cycle.
// No clearing pass after reset.
// Depends on frrjs_pkg, frrjs_if, frrjs_queue, frrjs_table and the assert header.
`include "fcfs_round_robin_job_scheduler_assert.svh"
module fcfs_round_robin_job_scheduler
(
    input  logic                  clk,
    input  logic                  rst_n,
    frrjs_job_if.sink             job,
    frrjs_result_if.source        result,
    frrjs_cfg_if.sink             cfg
);
    import frrjs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QRD,
        S_TRD
    } state_t;

    typedef struct packed {
        logic      accepted;
        out_time_t tick_time;
        logic      ran;
        pid_t      run_pid;
        logic      first_start;
        out_time_t response_time;
        logic      finished;
        out_time_t turnaround;
        logic      context_switch;
    } res_t;

    state_t              state_reg;
    state_t              state_next;
    policy_t             policy_reg;
    policy_t             policy_next;
    slice_t              slice_len_reg;
    slice_t              slice_len_next;
    time_t               time_reg;
    time_t               time_next;
    logic [MAX_JOBS-1:0] busy_reg;
    logic [MAX_JOBS-1:0] busy_next;
    logic                running_valid_reg;
    logic                running_valid_next;
    slot_t               running_slot_reg;
    slot_t               running_slot_next;
    slice_t              slice_left_reg;
    slice_t              slice_left_next;
    pid_t                last_pid_reg;
    pid_t                last_pid_next;
    logic                last_valid_reg;
    logic                last_valid_next;
    logic                disp_reg;
    logic                disp_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                res_reg;
    res_t                res_next;

    q_req_t              q_req;
    q_stat_t             q_stat;
    tbl_req_t            tbl_req;
    job_entry_t          cur;

    logic                job_fire;
    logic                cfg_fire;
    logic                have_free;
    slot_t               free_slot;
    burst_t              burst_fix;
    time_t               time_inc;
    burst_t              rem_new;
    slice_t              slice_new;
    logic                first_disp;

    frrjs_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .stat  (q_stat)
    );

    frrjs_table u_table
    (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (cur)
    );

    assign job.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign job_fire  = job.valid && job.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_comb
    begin
        have_free = 1'b0;
        free_slot = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                have_free = 1'b1;
                free_slot = slot_t'(i);
            end
        end
    end

    assign burst_fix  = (job.burst_ticks == '0) ? burst_t'(1) : job.burst_ticks;
    assign time_inc   = (time_reg == '1) ? time_reg : time_reg + time_t'(1);
    assign rem_new    = cur.remaining - burst_t'(cur.remaining != '0);
    assign slice_new  = slice_left_reg - slice_t'(slice_left_reg != '0);
    assign first_disp = disp_reg && !cur.started;

    always_comb
    begin
        state_next         = state_reg;
        policy_next        = policy_reg;
        slice_len_next     = slice_len_reg;
        time_next          = time_reg;
        busy_next          = busy_reg;
        running_valid_next = running_valid_reg;
        running_slot_next  = running_slot_reg;
        slice_left_next    = slice_left_reg;
        last_pid_next      = last_pid_reg;
        last_valid_next    = last_valid_reg;
        disp_next          = disp_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        res_next           = res_reg;
        q_req              = '0;
        tbl_req            = '0;

        if (cfg_fire)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_POLICY_MODE:  policy_next = policy_t'(cfg.data[0]);
                CFG_SLICE_LENGTH: slice_len_next = slice_t'(cfg.data);
                default:          policy_next = policy_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_fire)
                begin
                    if (job.func == FUNC_ADMIT)
                    begin
                        res_next          = '0;
                        res_next.accepted = have_free;
                        out_valid_next    = 1'b1;
                        if (have_free)
                        begin
                            tbl_req.wr_en     = 1'b1;
                            tbl_req.wr_addr   = free_slot;
                            tbl_req.wr_data   = '{pid: job.job_pid, arrival: time_reg,
                                                  remaining: burst_fix, started: 1'b0};
                            q_req.push        = 1'b1;
                            q_req.push_slot   = free_slot;
                            busy_next[free_slot] = 1'b1;
                        end
                    end
                    else if (!running_valid_reg && q_stat.count != '0)
                    begin
                        q_req.pop  = 1'b1;
                        state_next = S_QRD;
                    end
                    else if (running_valid_reg)
                    begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = running_slot_reg;
                        disp_next       = 1'b0;
                        state_next      = S_TRD;
                    end
                    else
                    begin
                        res_next           = '0;
                        res_next.tick_time = out_time_t'(time_reg);
                        out_valid_next     = 1'b1;
                        time_next          = time_inc;
                    end
                end
            end
            S_QRD:
            begin
                tbl_req.rd_en      = 1'b1;
                tbl_req.rd_addr    = q_stat.head_slot;
                running_slot_next  = q_stat.head_slot;
                running_valid_next = 1'b1;
                slice_left_next    = (slice_len_reg == '0) ? slice_t'(1) : slice_len_reg;
                disp_next          = 1'b1;
                state_next         = S_TRD;
            end
            S_TRD:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = running_slot_reg;
                tbl_req.wr_data = '{pid: cur.pid, arrival: cur.arrival, remaining: rem_new,
                                    started: cur.started || disp_reg};

                res_next                = '0;
                res_next.tick_time      = out_time_t'(time_reg);
                res_next.ran            = 1'b1;
                res_next.run_pid        = cur.pid;
                res_next.first_start    = first_disp;
                res_next.response_time  = first_disp ? out_time_t'(time_reg - cur.arrival) : '0;
                res_next.context_switch = last_valid_reg && (last_pid_reg != cur.pid);
                out_valid_next          = 1'b1;

                last_pid_next   = cur.pid;
                last_valid_next = 1'b1;
                slice_left_next = slice_new;
                time_next       = time_inc;

                if (rem_new == '0)
                begin
                    res_next.finished   = 1'b1;
                    res_next.turnaround = out_time_t'(time_inc - cur.arrival);
                    busy_next[running_slot_reg] = 1'b0;
                    running_valid_next  = 1'b0;
                end
                else if (policy_reg == POLICY_RR && slice_new == '0)
                begin
                    q_req.push         = 1'b1;
                    q_req.push_slot    = running_slot_reg;
                    running_valid_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            policy_reg        <= POLICY_FCFS;
            slice_len_reg     <= slice_t'(4);
            time_reg          <= '0;
            busy_reg          <= '0;
            running_valid_reg <= 1'b0;
            running_slot_reg  <= '0;
            slice_left_reg    <= '0;
            last_pid_reg      <= '0;
            last_valid_reg    <= 1'b0;
            disp_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            policy_reg        <= policy_next;
            slice_len_reg     <= slice_len_next;
            time_reg          <= time_next;
            busy_reg          <= busy_next;
            running_valid_reg <= running_valid_next;
            running_slot_reg  <= running_slot_next;
            slice_left_reg    <= slice_left_next;
            last_pid_reg      <= last_pid_next;
            last_valid_reg    <= last_valid_next;
            disp_reg          <= disp_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.accepted       = res_reg.accepted;
    assign result.tick_time      = res_reg.tick_time;
    assign result.ran            = res_reg.ran;
    assign result.run_pid        = res_reg.run_pid;
    assign result.first_start    = res_reg.first_start;
    assign result.response_time  = res_reg.response_time;
    assign result.finished       = res_reg.finished;
    assign result.turnaround     = res_reg.turnaround;
    assign result.context_switch = res_reg.context_switch;

    `FRRJS_ASSERT(a_trd_out_free, !(state_reg == S_TRD && out_valid_reg), "write-back with result register occupied")
    `FRRJS_ASSERT(a_busy_covers_jobs, $countones(busy_reg) >= int'(q_stat.count) + int'(running_valid_reg), "queued or running job without a busy slot")
    `FRRJS_ASSERT_NEXT(a_finish_frees, state_reg == S_TRD && rem_new == '0, !busy_reg[$past(running_slot_reg)] && !running_valid_reg, "finished job still holds its slot")

endmodule
